### rtl/contact_impulse_resolver_2d_top_defines.svh
// Assertion macros shared by the contact resolver RTL.
`ifndef CONTACT_IMPULSE_RESOLVER_2D_TOP_DEFINES_SVH
`define CONTACT_IMPULSE_RESOLVER_2D_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CIR_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CIR_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/cir_pkg.sv
// Shared types, widths and helpers of the contact resolver.
`timescale 1ns / 1ps
package cir_pkg;

	// Position and velocity accumulators keep headroom for impulse and push.
	localparam int WideW = 38;
	// Multiplier operands and product.
	localparam int MulAW = 36;
	localparam int MulBW = 33;
	localparam int ProdW = MulAW + MulBW;
	// Iterative unit: operand, divisor or root width, quotient bits.
	localparam int NumW  = 66;
	localparam int LenW  = 33;
	localparam int QuoW  = 25;
	localparam int NormW = 18;

	localparam logic signed [NormW-1:0] OneQ16    = 18'sd65536;
	localparam logic signed [NormW-1:0] MinusOneQ16 = -18'sd65536;

	localparam logic       ShapeCircle = 1'b0;
	localparam logic       ShapeBox    = 1'b1;
	localparam logic [1:0] KindStatic  = 2'd0;
	localparam logic [1:0] KindDynamic = 2'd1;

	// One body as held during a contact.
	typedef struct packed {
		logic signed [WideW-1:0] px;
		logic signed [WideW-1:0] py;
		logic signed [WideW-1:0] vx;
		logic signed [WideW-1:0] vy;
		logic [30:0]             hx;
		logic [30:0]             hy;
		logic [30:0]             m;
		logic [16:0]             e;
		logic                    shape;
		logic [1:0]              kind;
	} cir_body_t;

	// Request to the shared divide and root unit.
	typedef struct packed {
		logic go;
		logic is_sqrt;
	} cir_unit_req_t;

	// Response of the shared divide and root unit.
	typedef struct packed {
		logic            done;
		logic [LenW-1:0] value;
	} cir_unit_rsp_t;

	// Clamp a wide value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
		logic signed [WideW-1:0] hi;
		logic signed [WideW-1:0] lo;
		hi = 38'sd2147483647;
		lo = -38'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

### rtl/cir_divsqrt.sv
// Shared iterative unit: restoring divider and integer square root, one bit a cycle.
`timescale 1ns / 1ps
module cir_divsqrt import cir_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cir_unit_req_t   req,
	input  logic [NumW-1:0] opa,
	input  logic [LenW-1:0] opb,
	output cir_unit_rsp_t   rsp
);

	logic            run_q;
	logic            done_q;
	logic            mode_q;
	logic [5:0]      cnt_q;
	logic [NumW-1:0] shf_q;
	logic [35:0]     rem_q;
	logic [LenW-1:0] root_q;
	logic [LenW-1:0] div_q;

	logic [33:0] t_div;
	logic [33:0] d_ext;
	logic        ge_div;
	logic [35:0] t_sq;
	logic [35:0] trial;
	logic        ge_sq;

	// Trial subtraction for both modes.
	assign t_div  = {rem_q[32:0], shf_q[NumW-1]};
	assign d_ext  = {1'b0, div_q};
	assign ge_div = (t_div >= d_ext);
	assign t_sq   = {rem_q[33:0], shf_q[NumW-1:NumW-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge_sq  = (t_sq >= trial);

	// Sequencing of the iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == 6'd0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Remainder, root or quotient, and remaining operand bits.
	always_ff @(posedge clk) begin
		if (req.go) begin
			mode_q <= req.is_sqrt;
			div_q  <= opb;
			root_q <= '0;
			if (req.is_sqrt) begin
				cnt_q <= 6'(LenW - 1);
				shf_q <= opa;
				rem_q <= '0;
			end else begin
				cnt_q <= 6'(QuoW - 1);
				shf_q <= {opa[QuoW-1:0], {(NumW-QuoW){1'b0}}};
				rem_q <= 36'(opa[55:QuoW]);
			end
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (mode_q) begin
				shf_q  <= {shf_q[NumW-3:0], 2'b00};
				root_q <= {root_q[LenW-2:0], ge_sq};
				rem_q  <= ge_sq ? (t_sq - trial) : t_sq;
			end else begin
				shf_q  <= {shf_q[NumW-2:0], 1'b0};
				root_q <= {root_q[LenW-2:0], ge_div};
				rem_q  <= 36'(ge_div ? (t_div - d_ext) : t_div);
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = root_q;

endmodule

### rtl/contact_impulse_resolver_2d_top.sv
// Top level of the two-body contact resolver for circles and axis-aligned boxes.
`timescale 1ns / 1ps
// Usage: a body word is accepted at a rising edge with start high and busy low.
// A word with is_second low is stored as the first body; it gives no result and
// busy stays low. A word with is_second high is paired with the stored body and
// raises busy for the whole resolution.
// Results leave as two words on consecutive cycles, each marked by result_strobe:
// first the stored body (body_index 0), then the new one (body_index 1, last 1).
// The receiver cannot stall; each word is valid for exactly one cycle.
// Steps: one multiplier step per product and a run of the shared divide and root
// unit per division and for the root. A circle contact with mass takes longer
// than a box pair, and a pair with zero total mass goes from the normal straight
// to the result words. Busy holds off the next word, so one contact is resolved
// at a time.
// Reset clears the sequencer, the stored shape and kind tags and the last normal;
// the stored body data is undefined until a first body is loaded.
module contact_impulse_resolver_2d_top import cir_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               is_second,
	input  logic               shape_kind,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [30:0]        half_x,
	input  logic [30:0]        half_y,
	input  logic [30:0]        mass,
	input  logic [16:0]        bounce,
	input  logic [1:0]         body_kind,
	output logic               result_strobe,
	output logic               body_index,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic               last
);
`include "contact_impulse_resolver_2d_top_defines.svh"

	typedef enum logic [5:0] {
		S_IDLE, S_GEO, S_SQX, S_SQY, S_SQ_GO, S_SQ_WAIT,
		S_NX_GO, S_NX_WAIT, S_NY_GO, S_NY_WAIT, S_NRM,
		S_ME0, S_ME1, S_R_GO, S_R_WAIT, S_Q0_GO, S_Q0_WAIT, S_Q1_GO, S_Q1_WAIT,
		S_SEPX, S_SEPY, S_SEP, S_DV, S_S0, S_S1,
		S_I0X, S_I0Y, S_I1X, S_I1Y, S_IEND, S_PENCHK,
		S_T0, S_T1, S_P0X, S_P0Y, S_P1X, S_P1Y, S_PEND,
		S_OUT0, S_OUT1
	} state_t;

	state_t state_q;

	// Stored first body and its tags.
	cir_body_t  fb_q;
	logic       fb_shape_q;
	logic [1:0] fb_kind_q;
	logic signed [NormW-1:0] last_nx_q;
	logic signed [NormW-1:0] last_ny_q;

	// Working bodies: a is the body the normal points toward.
	cir_body_t a_q;
	cir_body_t b_q;
	logic      swap_q;
	logic      cc_q;
	logic      rr_q;

	logic signed [33:0]      dx_q;
	logic signed [33:0]      dy_q;
	logic [LenW-1:0]         len_q;
	logic signed [34:0]      pen_q;
	logic signed [NormW-1:0] nx_q;
	logic signed [NormW-1:0] ny_q;
	logic [31:0]             msum_q;
	logic [16:0]             rest_q;
	logic [QuoW-1:0]         q0_q;
	logic [QuoW-1:0]         q1_q;
	logic signed [34:0]      sep_q;
	logic [34:0]             dv_q;
	logic [34:0]             s0_q;
	logic [34:0]             s1_q;
	logic [32:0]             t0_q;
	logic [32:0]             t1_q;
	logic signed [ProdW-1:0] acc_q;
	logic signed [ProdW-1:0] prod_q;

	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	cir_unit_req_t           ureq;
	cir_unit_rsp_t           ursp;
	logic [NumW-1:0]         uopa;
	logic [LenW-1:0]         uopb;

	logic       accept;
	cir_body_t  in_body;
	cir_body_t  st_body;

	// Accept and the body built from the ports and from the store.
	assign accept = start && !busy;
	always_comb begin
		in_body       = '0;
		in_body.px    = WideW'(pos_x);
		in_body.py    = WideW'(pos_y);
		in_body.vx    = WideW'(vel_x);
		in_body.vy    = WideW'(vel_y);
		in_body.hx    = half_x;
		in_body.hy    = half_y;
		in_body.m     = mass;
		in_body.e     = bounce;
		in_body.shape = shape_kind;
		in_body.kind  = body_kind;
		st_body       = fb_q;
		st_body.shape = fb_shape_q;
		st_body.kind  = fb_kind_q;
	end

	// Geometry of the pair: center deltas, box clamp, box-box penetration.
	logic signed [WideW-1:0] g_lo_x, g_hi_x, g_lo_y, g_hi_y, g_cx, g_cy;
	logic signed [WideW-1:0] g_dx, g_dy, g_adx, g_ady, g_penx, g_peny;
	logic                    g_cr;
	always_comb begin
		g_cr   = (a_q.shape == ShapeCircle) && (b_q.shape == ShapeBox);
		g_lo_x = b_q.px - $signed(WideW'(b_q.hx));
		g_hi_x = b_q.px + $signed(WideW'(b_q.hx));
		g_lo_y = b_q.py - $signed(WideW'(b_q.hy));
		g_hi_y = b_q.py + $signed(WideW'(b_q.hy));
		g_cx   = (a_q.px < g_lo_x) ? g_lo_x : ((a_q.px > g_hi_x) ? g_hi_x : a_q.px);
		g_cy   = (a_q.py < g_lo_y) ? g_lo_y : ((a_q.py > g_hi_y) ? g_hi_y : a_q.py);
		g_dx   = g_cr ? (a_q.px - g_cx) : (a_q.px - b_q.px);
		g_dy   = g_cr ? (a_q.py - g_cy) : (a_q.py - b_q.py);
		g_adx  = g_dx[WideW-1] ? -g_dx : g_dx;
		g_ady  = g_dy[WideW-1] ? -g_dy : g_dy;
		g_penx = $signed(WideW'(a_q.hx)) + $signed(WideW'(b_q.hx)) - g_adx;
		g_peny = $signed(WideW'(a_q.hy)) + $signed(WideW'(b_q.hy)) - g_ady;
	end

	// Magnitudes of the stored deltas and helper values.
	logic signed [33:0]      adx_w, ady_w;
	logic [31:0]             adx, ady;
	logic signed [MulBW-1:0] nx_ext, ny_ext;
	logic signed [WideW-1:0] dvx, dvy;
	logic [31:0]             msum_w;
	logic signed [69:0]      sep_sum;
	logic signed [34:0]      sep_w;
	logic signed [34:0]      negsep;
	logic [17:0]             rest_one;
	logic signed [WideW-1:0] pen_cc, pen_cr, pen_len;
	logic signed [NormW-1:0] unit_pos, unit_neg;
	logic [1:0]              c0, c1;
	logic signed [36:0]      imp_f;
	logic signed [34:0]      push_f;
	always_comb begin
		adx_w    = dx_q[33] ? -dx_q : dx_q;
		ady_w    = dy_q[33] ? -dy_q : dy_q;
		adx      = adx_w[31:0];
		ady      = ady_w[31:0];
		nx_ext   = MulBW'(nx_q);
		ny_ext   = MulBW'(ny_q);
		dvx      = a_q.vx - b_q.vx;
		dvy      = a_q.vy - b_q.vy;
		msum_w   = 32'(a_q.m) + 32'(b_q.m);
		sep_sum  = 70'(acc_q) + 70'(prod_q);
		sep_w    = sep_sum[50:16];
		negsep   = -sep_q;
		rest_one = 18'(OneQ16) + 18'(rest_q);
		pen_cc   = $signed(WideW'(a_q.hx)) + $signed(WideW'(b_q.hx))
			- $signed(WideW'(ursp.value));
		pen_cr   = $signed(WideW'(a_q.hx)) - $signed(WideW'(ursp.value));
		pen_len  = cc_q ? pen_cc : pen_cr;
		unit_pos = $signed({1'b0, ursp.value[16:0]});
		unit_neg = -unit_pos;
		c0       = 2'(a_q.kind == KindDynamic) + 2'(b_q.kind == KindStatic);
		c1       = 2'(a_q.kind == KindStatic) + 2'(b_q.kind == KindDynamic);
		imp_f    = prod_q[52:16];
		push_f   = prod_q[50:16];
	end

	// An impulse counted zero, one or two times.
	function automatic logic signed [WideW-1:0] times(input logic [1:0] c,
			input logic signed [36:0] f);
		logic signed [WideW-1:0] fx;
		fx = WideW'(f);
		case (c)
			2'd1: return fx;
			2'd2: return fx <<< 1;
			default: return '0;
		endcase
	endfunction

	// Operands of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQX: begin
				mul_a = $signed({4'b0, adx});
				mul_b = $signed({1'b0, adx});
			end
			S_SQY: begin
				mul_a = $signed({4'b0, ady});
				mul_b = $signed({1'b0, ady});
			end
			S_ME0: begin
				mul_a = $signed(MulAW'(a_q.m));
				mul_b = $signed(MulBW'(a_q.e));
			end
			S_ME1: begin
				mul_a = $signed(MulAW'(b_q.m));
				mul_b = $signed(MulBW'(b_q.e));
			end
			S_SEPX: begin
				mul_a = dvx[MulAW-1:0];
				mul_b = nx_ext;
			end
			S_SEPY: begin
				mul_a = dvy[MulAW-1:0];
				mul_b = ny_ext;
			end
			S_DV: begin
				mul_a = MulAW'(negsep);
				mul_b = $signed(MulBW'(rest_one));
			end
			S_S0: begin
				mul_a = $signed({1'b0, prod_q[50:16]});
				mul_b = $signed(MulBW'(q0_q));
			end
			S_S1: begin
				mul_a = $signed({1'b0, dv_q});
				mul_b = $signed(MulBW'(q1_q));
			end
			S_I0X: begin
				mul_a = $signed({1'b0, s0_q});
				mul_b = nx_ext;
			end
			S_I0Y: begin
				mul_a = $signed({1'b0, s0_q});
				mul_b = ny_ext;
			end
			S_I1X: begin
				mul_a = $signed({1'b0, s1_q});
				mul_b = nx_ext;
			end
			S_I1Y: begin
				mul_a = $signed({1'b0, s1_q});
				mul_b = ny_ext;
			end
			S_T0: begin
				mul_a = MulAW'(pen_q);
				mul_b = $signed(MulBW'(q0_q));
			end
			S_T1: begin
				mul_a = MulAW'(pen_q);
				mul_b = $signed(MulBW'(q1_q));
			end
			S_P0X: begin
				mul_a = $signed({3'b0, t0_q});
				mul_b = nx_ext;
			end
			S_P0Y: begin
				mul_a = $signed({3'b0, t0_q});
				mul_b = ny_ext;
			end
			S_P1X: begin
				mul_a = $signed({3'b0, t1_q});
				mul_b = nx_ext;
			end
			S_P1Y: begin
				mul_a = $signed({3'b0, t1_q});
				mul_b = ny_ext;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Requests to the divide and root unit.
	always_comb begin
		ureq.go      = 1'b0;
		ureq.is_sqrt = 1'b0;
		uopa         = '0;
		uopb         = LenW'(msum_q);
		case (state_q)
			S_SQ_GO: begin
				ureq.go      = 1'b1;
				ureq.is_sqrt = 1'b1;
				uopa         = NumW'(acc_q[63:0]) + NumW'(prod_q[63:0]);
			end
			S_NX_GO: begin
				ureq.go = 1'b1;
				uopa    = NumW'({adx, 16'b0});
				uopb    = len_q;
			end
			S_NY_GO: begin
				ureq.go = 1'b1;
				uopa    = NumW'({ady, 16'b0});
				uopb    = len_q;
			end
			S_R_GO: begin
				ureq.go = 1'b1;
				uopa    = NumW'(acc_q[48:0]) + NumW'(prod_q[48:0]);
			end
			S_Q0_GO: begin
				ureq.go = 1'b1;
				uopa    = NumW'({b_q.m, 24'b0});
			end
			S_Q1_GO: begin
				ureq.go = 1'b1;
				uopa    = NumW'({a_q.m, 24'b0});
			end
			default: begin
				ureq.go = 1'b0;
			end
		endcase
	end

	cir_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.opa    (uopa),
		.opb    (uopb),
		.rsp    (ursp)
	);

	// Product register of the shared multiplier.
	always_ff @(posedge clk) begin
		prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
	end

	// Sequencer, stored tags and last normal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fb_shape_q <= 1'b0;
			fb_kind_q  <= KindStatic;
			last_nx_q  <= '0;
			last_ny_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && !is_second) begin
						fb_shape_q <= shape_kind;
						fb_kind_q  <= body_kind;
					end else if (accept) begin
						state_q <= S_GEO;
					end
				end
				S_GEO: state_q <= (a_q.shape == ShapeBox) ? S_NRM : S_SQX;
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SQ_GO;
				S_SQ_GO: state_q <= S_SQ_WAIT;
				S_SQ_WAIT: begin
					if (ursp.done) begin
						state_q <= (ursp.value != '0) ? S_NX_GO : S_NRM;
					end
				end
				S_NX_GO: state_q <= S_NX_WAIT;
				S_NX_WAIT: if (ursp.done) state_q <= S_NY_GO;
				S_NY_GO: state_q <= S_NY_WAIT;
				S_NY_WAIT: if (ursp.done) state_q <= S_NRM;
				S_NRM: begin
					last_nx_q <= nx_q;
					last_ny_q <= ny_q;
					state_q   <= (msum_w == '0) ? S_OUT0 : S_ME0;
				end
				S_ME0: state_q <= S_ME1;
				S_ME1: state_q <= S_R_GO;
				S_R_GO: state_q <= S_R_WAIT;
				S_R_WAIT: if (ursp.done) state_q <= S_Q0_GO;
				S_Q0_GO: state_q <= S_Q0_WAIT;
				S_Q0_WAIT: if (ursp.done) state_q <= S_Q1_GO;
				S_Q1_GO: state_q <= S_Q1_WAIT;
				S_Q1_WAIT: if (ursp.done) state_q <= S_SEPX;
				S_SEPX: state_q <= S_SEPY;
				S_SEPY: state_q <= S_SEP;
				S_SEP: state_q <= (sep_w <= 35'sd0) ? S_DV : S_PENCHK;
				S_DV: state_q <= S_S0;
				S_S0: state_q <= S_S1;
				S_S1: state_q <= S_I0X;
				S_I0X: state_q <= S_I0Y;
				S_I0Y: state_q <= S_I1X;
				S_I1X: state_q <= S_I1Y;
				S_I1Y: state_q <= S_IEND;
				S_IEND: state_q <= S_PENCHK;
				S_PENCHK: state_q <= (pen_q > 35'sd0) ? S_T0 : S_OUT0;
				S_T0: state_q <= S_T1;
				S_T1: state_q <= S_P0X;
				S_P0X: state_q <= S_P0Y;
				S_P0Y: state_q <= S_P1X;
				S_P1X: state_q <= S_P1Y;
				S_P1Y: state_q <= S_PEND;
				S_PEND: state_q <= S_OUT0;
				S_OUT0: state_q <= S_OUT1;
				S_OUT1: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers, updated step by step.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && !is_second) begin
					fb_q <= in_body;
				end else if (accept) begin
					if (fb_shape_q == ShapeBox && shape_kind == ShapeCircle) begin
						a_q <= in_body;
						b_q <= st_body;
					end else begin
						a_q <= st_body;
						b_q <= in_body;
					end
					swap_q <= (fb_shape_q == ShapeBox) && (shape_kind == ShapeCircle);
				end
			end
			S_GEO: begin
				dx_q <= g_dx[33:0];
				dy_q <= g_dy[33:0];
				cc_q <= (a_q.shape == ShapeCircle) && (b_q.shape == ShapeCircle);
				rr_q <= (a_q.shape == ShapeBox);
				if (a_q.shape == ShapeBox) begin
					if (g_penx < g_peny) begin
						pen_q <= g_penx[34:0];
						nx_q  <= (g_dx > 38'sd0) ? OneQ16 : MinusOneQ16;
						ny_q  <= '0;
					end else begin
						pen_q <= g_peny[34:0];
						nx_q  <= '0;
						ny_q  <= (g_dy > 38'sd0) ? OneQ16 : MinusOneQ16;
					end
				end else begin
					nx_q <= last_nx_q;
					ny_q <= last_ny_q;
				end
			end
			S_SQY, S_ME1, S_SEPY: acc_q <= prod_q;
			S_SQ_WAIT: begin
				if (ursp.done) begin
					len_q <= ursp.value;
					pen_q <= pen_len[34:0];
					if (cc_q && ursp.value == '0) begin
						nx_q <= '0;
						ny_q <= '0;
					end
				end
			end
			S_NX_WAIT: if (ursp.done) nx_q <= dx_q[33] ? unit_neg : unit_pos;
			S_NY_WAIT: if (ursp.done) ny_q <= dy_q[33] ? unit_neg : unit_pos;
			S_NRM: msum_q <= msum_w;
			S_R_WAIT: if (ursp.done) rest_q <= ursp.value[16:0];
			S_Q0_WAIT: if (ursp.done) q0_q <= ursp.value[QuoW-1:0];
			S_Q1_WAIT: if (ursp.done) q1_q <= ursp.value[QuoW-1:0];
			S_SEP: sep_q <= sep_w;
			S_S0: dv_q <= prod_q[50:16];
			S_S1: s0_q <= prod_q[58:24];
			S_I0X: s1_q <= prod_q[58:24];
			S_I0Y: a_q.vx <= a_q.vx + times(c0, imp_f);
			S_I1X: a_q.vy <= a_q.vy + times(c0, imp_f);
			S_I1Y: b_q.vx <= b_q.vx - times(c1, imp_f);
			S_IEND: b_q.vy <= b_q.vy - times(c1, imp_f);
			S_T1: t0_q <= prod_q[56:24];
			S_P0X: t1_q <= prod_q[56:24];
			S_P0Y: if (a_q.kind == KindDynamic) a_q.px <= a_q.px + WideW'(push_f);
			S_P1X: if (a_q.kind == KindDynamic) a_q.py <= a_q.py + WideW'(push_f);
			S_P1Y: if (b_q.kind == KindDynamic) b_q.px <= b_q.px - WideW'(push_f);
			S_PEND: if (b_q.kind == KindDynamic) b_q.py <= b_q.py - WideW'(push_f);
			default: begin
				rr_q <= rr_q;
			end
		endcase
	end

	// Result words in load order.
	cir_body_t out_body;
	always_comb begin
		if ((state_q == S_OUT0) != swap_q) begin
			out_body = a_q;
		end else begin
			out_body = b_q;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = (state_q == S_OUT0) || (state_q == S_OUT1);
	assign body_index    = (state_q == S_OUT1);
	assign last          = (state_q == S_OUT1);
	assign new_pos_x     = sat32(out_body.px);
	assign new_pos_y     = sat32(out_body.py);
	assign new_vel_x     = sat32(out_body.vx);
	assign new_vel_y     = sat32(out_body.vy);

	// Checks on the sequencer.
	`CIR_ASSERT_IMP(a_strobe_busy, result_strobe, busy, "result word outside a contact")
	`CIR_ASSERT_NXT(a_pair_order, result_strobe && !last, result_strobe && last, "second word missing")
	`CIR_ASSERT_NXT(a_end_idle, result_strobe && last, !busy, "busy after the last word")
	`CIR_ASSERT_NXT(a_start_busy, accept && is_second, busy && !result_strobe, "contact not started")
	`CIR_ASSERT_NXT(a_load_quiet, accept && !is_second, !busy, "first body raised busy")
	`CIR_ASSERT_IMP(a_box_pair, busy && rr_q && state_q == S_SQ_GO, 1'b0, "root on a box pair")

endmodule
